// ===== hdl/i2cbe_pkg.sv =====
// Shared types and constants of the I2C master bit engine.
// Has no dependencies; every other file of the block imports it.
`default_nettype none

package i2cbe_pkg;

	// Operation codes of an incoming beat.
	localparam logic [2:0] OP_START = 3'd0;
	localparam logic [2:0] OP_STOP  = 3'd1;
	localparam logic [2:0] OP_WRITE = 3'd2;
	localparam logic [2:0] OP_READ  = 3'd3;
	localparam logic [2:0] OP_TICK  = 3'd4;

	// Sequence kinds as held by the engine.
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_STOP  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	// Classification made by the front end.
	localparam logic [1:0] KIND_NOP  = 2'd0;
	localparam logic [1:0] KIND_CMD  = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;

	localparam int STEP_W = 5;

	// Step numbers of the start and stop sequences.
	localparam logic [STEP_W-1:0] SS_SCL_LOW = 5'd0;
	localparam logic [STEP_W-1:0] SS_SDA_1ST = 5'd1;
	localparam logic [STEP_W-1:0] SS_SCL_HI  = 5'd2;

	// Step numbers of the write sequence.
	localparam logic [STEP_W-1:0] WR_RELEASE  = 5'd24;
	localparam logic [STEP_W-1:0] WR_SCL_LOW  = 5'd25;
	localparam logic [STEP_W-1:0] WR_SCL_HI   = 5'd26;

	// Step numbers of the read sequence.
	localparam logic [STEP_W-1:0] RD_RELEASE  = 5'd0;
	localparam logic [STEP_W-1:0] RD_FIRST_BIT = 5'd3;
	localparam logic [STEP_W-1:0] RD_CLK_END  = 5'd16;
	localparam logic [STEP_W-1:0] RD_LAST_BIT = 5'd17;
	localparam logic [STEP_W-1:0] RD_ACK_LOW  = 5'd18;
	localparam logic [STEP_W-1:0] RD_ACK_DRV  = 5'd19;

	// Phase of one write bit: SCL low, drive data, SCL high.
	localparam logic [1:0] PH_SCL_LOW = 2'd0;
	localparam logic [1:0] PH_DATA    = 2'd1;
	localparam logic [1:0] PH_SCL_HI  = 2'd2;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] write_byte;
		logic       send_ack;
		logic       sda_sample;
	} cmd_beat_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_released;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_seen;
		logic       rejected;
	} rsp_beat_t;

	// Classified item passed from front to back.
	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] cmd;
		logic [7:0] write_byte;
		logic       send_ack;
		logic       sda_sample;
	} item_t;

endpackage

`default_nettype wire

// ===== hdl/i2cbe_front.sv =====
// Front end: decodes the operation code of each beat into an item kind.
// Depends on i2cbe_pkg.
`default_nettype none

module i2cbe_front (
	input  wire i2cbe_pkg::cmd_beat_t beat,
	output i2cbe_pkg::item_t          item
);
	import i2cbe_pkg::*;

	always_comb begin
		item.cmd        = beat.op[1:0];
		item.write_byte = beat.write_byte;
		item.send_ack   = beat.send_ack;
		item.sda_sample = beat.sda_sample;
		case (beat.op)
			OP_START, OP_STOP, OP_WRITE, OP_READ: item.kind = KIND_CMD;
			OP_TICK:                              item.kind = KIND_TICK;
			default:                              item.kind = KIND_NOP;
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/i2cbe_fifo.sv =====
// Two-entry queue of classified items between front and back.
// Depends on i2cbe_pkg.
`default_nettype none

module i2cbe_fifo (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     push,
	input  wire i2cbe_pkg::item_t   push_item,
	output logic                    full,
	input  wire                     pop,
	output logic                    not_empty,
	output i2cbe_pkg::item_t        head
);
	import i2cbe_pkg::*;

	item_t       mem_q [2];
	logic        wptr_q;
	logic        rptr_q;
	logic [1:0]  count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/i2cbe_back.sv =====
// Back end: runs the start, stop, write and read pin sequences and holds
// the result register. Depends on i2cbe_pkg.
`default_nettype none

module i2cbe_back (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     item_valid,
	input  wire i2cbe_pkg::item_t   item,
	output logic                    item_pop,
	output logic                    rsp_valid,
	input  wire                     rsp_stall,
	output i2cbe_pkg::rsp_beat_t    rsp_beat
);
	import i2cbe_pkg::*;

	logic              scl_q, sda_q, rel_q, busy_q, ackc_q, ackf_q;
	logic [1:0]        cmd_q, ph_q;
	logic [STEP_W-1:0] step_q;
	logic [7:0]        shift_q, rxb_q;

	logic              scl_d, sda_d, rel_d, busy_d, ackc_d, ackf_d;
	logic [1:0]        cmd_d, ph_d;
	logic [STEP_W-1:0] step_d;
	logic [7:0]        shift_d, rxb_d;
	logic              done, rej, fin;

	logic              rsp_valid_q;
	rsp_beat_t         rsp_q;

	assign item_pop  = item_valid && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp_beat  = rsp_q;

	always_comb begin
		scl_d   = scl_q;
		sda_d   = sda_q;
		rel_d   = rel_q;
		busy_d  = busy_q;
		ackc_d  = ackc_q;
		ackf_d  = ackf_q;
		cmd_d   = cmd_q;
		ph_d    = ph_q;
		step_d  = step_q;
		shift_d = shift_q;
		rxb_d   = rxb_q;
		done    = 1'b0;
		rej     = 1'b0;
		fin     = 1'b0;
		case (item.kind)
			KIND_CMD: begin
				if (busy_q) begin
					rej = 1'b1;
				end else begin
					cmd_d  = item.cmd;
					busy_d = 1'b1;
					step_d = '0;
					ph_d   = PH_SCL_LOW;
					if (item.cmd == CMD_WRITE) begin
						shift_d = item.write_byte;
					end else if (item.cmd == CMD_READ) begin
						shift_d = '0;
						ackc_d  = item.send_ack;
					end
				end
			end
			KIND_TICK: begin
				if (busy_q) begin
					case (cmd_q)
						CMD_START, CMD_STOP: begin
							if (step_q == SS_SCL_LOW) begin
								scl_d = 1'b0;
							end else if (step_q == SS_SDA_1ST) begin
								sda_d = (cmd_q == CMD_START);
							end else if (step_q == SS_SCL_HI) begin
								scl_d = 1'b1;
							end else begin
								sda_d = (cmd_q != CMD_START);
								fin   = 1'b1;
							end
						end
						CMD_WRITE: begin
							if (step_q < WR_RELEASE) begin
								// Data bits go out MSB first from the shift register.
								case (ph_q)
									PH_SCL_LOW: scl_d = 1'b0;
									PH_DATA: begin
										sda_d   = shift_q[7];
										shift_d = {shift_q[6:0], 1'b0};
									end
									default: scl_d = 1'b1;
								endcase
								ph_d = (ph_q == PH_SCL_HI) ? PH_SCL_LOW : ph_q + 2'd1;
							end else if (step_q == WR_RELEASE) begin
								rel_d = 1'b1;
							end else if (step_q == WR_SCL_LOW) begin
								scl_d = 1'b0;
							end else if (step_q == WR_SCL_HI) begin
								scl_d = 1'b1;
							end else begin
								ackf_d = ~item.sda_sample;
								rel_d  = 1'b0;
								fin    = 1'b1;
							end
						end
						default: begin
							// The sample taken at the start of a tick that follows SCL high.
							if (step_q >= RD_FIRST_BIT && step_q <= RD_LAST_BIT && step_q[0]) begin
								shift_d = {shift_q[6:0], item.sda_sample};
							end
							if (step_q == RD_RELEASE) begin
								rel_d = 1'b1;
							end else if (step_q <= RD_CLK_END) begin
								scl_d = ~step_q[0];
							end else if (step_q == RD_LAST_BIT) begin
								rel_d = 1'b0;
								rxb_d = shift_d;
							end else if (step_q == RD_ACK_LOW) begin
								scl_d = 1'b0;
							end else if (step_q == RD_ACK_DRV) begin
								sda_d = ~ackc_q;
							end else begin
								scl_d = 1'b1;
								fin   = 1'b1;
							end
						end
					endcase
					if (fin) begin
						busy_d = 1'b0;
						step_d = '0;
						done   = 1'b1;
					end else begin
						step_d = step_q + 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			rel_q       <= 1'b0;
			busy_q      <= 1'b0;
			ackc_q      <= 1'b0;
			ackf_q      <= 1'b0;
			cmd_q       <= CMD_START;
			ph_q        <= PH_SCL_LOW;
			step_q      <= '0;
			shift_q     <= '0;
			rxb_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (item_pop) begin
				scl_q   <= scl_d;
				sda_q   <= sda_d;
				rel_q   <= rel_d;
				busy_q  <= busy_d;
				ackc_q  <= ackc_d;
				ackf_q  <= ackf_d;
				cmd_q   <= cmd_d;
				ph_q    <= ph_d;
				step_q  <= step_d;
				shift_q <= shift_d;
				rxb_q   <= rxb_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			rsp_q.scl_level    <= scl_d;
			rsp_q.sda_level    <= sda_d;
			rsp_q.sda_released <= rel_d;
			rsp_q.busy_res     <= busy_d;
			rsp_q.done_res     <= done;
			rsp_q.rx_byte      <= rxb_d;
			rsp_q.ack_seen     <= ackf_d;
			rsp_q.rejected     <= rej;
		end
	end

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.done_res |-> !rsp_q.busy_res)
		else $error("done reported while sequence still busy");

	a_reject_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.rejected |-> rsp_q.busy_res && !rsp_q.done_res)
		else $error("rejection reported while idle or at sequence end");

	a_idle_step_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> step_q == '0)
		else $error("step counter not cleared while idle");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_stall |=> !$past(item_pop) || busy_q == $past(busy_q))
		else $error("engine state advanced while result was stalled");

endmodule

`default_nettype wire

// ===== hdl/i2c_master_bit_engine_core.sv =====
// Top level of the I2C master bit engine: front decoder, item queue and
// sequencing back end. Depends on i2cbe_pkg, i2cbe_front, i2cbe_fifo, i2cbe_back.
// A result beat passes through the queue and then the back end's result register;
// an output stall can hold its input beat in the queue between the two.
// Throughput: one beat per cycle while the output is not stalled; each tick performs one pin action of the sequencer.
// On output stall the queue fills up to two entries: one more beat in a steady stream.
// Reset (arst_n low) sets both lines high, driving SDA, idle, queue empty.
`default_nettype none

module i2c_master_bit_engine_core (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cmd_valid,
	output logic                      cmd_stall,
	input  wire i2cbe_pkg::cmd_beat_t cmd_beat,
	output logic                      rsp_valid,
	input  wire                       rsp_stall,
	output i2cbe_pkg::rsp_beat_t      rsp_beat
);
	import i2cbe_pkg::*;

	item_t dec_item;
	item_t head_item;
	logic  q_full;
	logic  q_not_empty;
	logic  q_pop;
	logic  q_push;

	// The front end classifies every beat in the cycle it arrives; the
	// queue absorbs beats whenever it has room.
	assign cmd_stall = q_full;
	assign q_push    = cmd_valid && !q_full;

	i2cbe_front u_front (
		.beat (cmd_beat),
		.item (dec_item)
	);

	i2cbe_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (dec_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (head_item)
	);

	// The back end owns all line and sequence state. It takes the queue head
	// whenever its result register is empty or being drained this cycle.
	i2cbe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_not_empty),
		.item       (head_item),
		.item_pop   (q_pop),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp_beat   (rsp_beat)
	);

endmodule

`default_nettype wire

// ===== bench/i2c_master_bit_engine_core_tb.sv =====
// Self-checking bench for the I2C master bit engine: directed line sequences, back-pressure
// and random command traffic, each result beat checked against an in-bench line predictor.
// Depends on i2cbe_pkg and i2c_master_bit_engine_core.
`timescale 1ns / 1ps

module i2c_master_bit_engine_core_tb;
	import i2cbe_pkg::*;

	// Ops 5 to 7 carry no meaning; the engine must treat them as no-ops.
	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	// Number of tick beats each sequence needs to run to its end.
	localparam int START_STOP_TICKS = 4;
	localparam int WRITE_TICKS      = 28;
	localparam int READ_TICKS       = 21;

	localparam int RANDOM_BEATS = 600;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	cmd_beat_t cmd_beat = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_beat_t rsp_beat;

	// Shadow copy of the engine's line and sequencer state, reset values included.
	logic       line_scl     = 1'b1;
	logic       line_sda     = 1'b1;
	logic       sda_tristate = 1'b0;
	logic       seq_busy     = 1'b0;
	logic [1:0] seq_kind     = CMD_START;
	logic [4:0] seq_step     = '0;
	logic [7:0] bit_shifter  = '0;
	logic       ack_to_send  = 1'b0;
	logic [7:0] rx_hold      = '0;
	logic       ack_hold     = 1'b0;

	rsp_beat_t expected_rsp[$];

	// Knobs shared by the test tasks and the idling processes.
	bit src_idle  = 1'b0;
	bit sink_idle = 1'b0;
	int hold_left = 0;

	int error_count  = 0;
	int beats_sent   = 0;
	int live_beats   = 0;
	int rsp_checked  = 0;
	int seq_finished = 0;
	int cmd_refused  = 0;

	i2c_master_bit_engine_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_beat  (cmd_beat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_beat  (rsp_beat)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Advances the shadow engine by one accepted beat and returns the result it must report.
	// A command only loads a sequence; each tick performs exactly one pin action of it.
	function automatic rsp_beat_t engine_predict(input cmd_beat_t b);
		rsp_beat_t r;
		logic      fin;
		logic      first_sda;
		r   = '0;
		fin = 1'b0;
		if (b.op <= OP_READ) begin
			if (seq_busy) begin
				r.rejected = 1'b1;
			end else begin
				seq_kind = b.op[1:0];
				seq_busy = 1'b1;
				seq_step = '0;
				if (b.op == OP_WRITE) begin
					bit_shifter = b.write_byte;
				end else if (b.op == OP_READ) begin
					bit_shifter = '0;
					ack_to_send = b.send_ack;
				end
			end
		end else if (b.op == OP_TICK && seq_busy) begin
			case (seq_kind)
				CMD_START, CMD_STOP: begin
					// Start pulls SDA low while SCL is high, stop lets it rise.
					first_sda = (seq_kind == CMD_START);
					case (seq_step)
						SS_SCL_LOW: line_scl = 1'b0;
						SS_SDA_1ST: line_sda = first_sda;
						SS_SCL_HI:  line_scl = 1'b1;
						default: begin
							line_sda = ~first_sda;
							fin      = 1'b1;
						end
					endcase
				end
				CMD_WRITE: begin
					if (seq_step < WR_RELEASE) begin
						case (2'(seq_step % 3))
							PH_SCL_LOW: line_scl = 1'b0;
							PH_DATA:    line_sda = bit_shifter[3'(7 - seq_step / 3)];
							default:    line_scl = 1'b1;
						endcase
					end else if (seq_step == WR_RELEASE) begin
						sda_tristate = 1'b1;
					end else if (seq_step == WR_SCL_LOW) begin
						line_scl = 1'b0;
					end else if (seq_step == WR_SCL_HI) begin
						line_scl = 1'b1;
					end else begin
						// Low on the line means the slave acknowledged.
						ack_hold     = ~b.sda_sample;
						sda_tristate = 1'b0;
						fin          = 1'b1;
					end
				end
				default: begin
					// The sample is taken before this tick's own pin action.
					if (seq_step >= RD_FIRST_BIT && seq_step <= RD_LAST_BIT && seq_step[0])
						bit_shifter = {bit_shifter[6:0], b.sda_sample};
					if (seq_step == RD_RELEASE) begin
						sda_tristate = 1'b1;
					end else if (seq_step <= RD_CLK_END) begin
						line_scl = ~seq_step[0];
					end else if (seq_step == RD_LAST_BIT) begin
						sda_tristate = 1'b0;
						rx_hold      = bit_shifter;
					end else if (seq_step == RD_ACK_LOW) begin
						line_scl = 1'b0;
					end else if (seq_step == RD_ACK_DRV) begin
						line_sda = ~ack_to_send;
					end else begin
						line_scl = 1'b1;
						fin      = 1'b1;
					end
				end
			endcase
			if (fin) begin
				seq_busy = 1'b0;
				seq_step = '0;
			end else begin
				seq_step = seq_step + 5'd1;
			end
		end
		r.scl_level    = line_scl;
		r.sda_level    = line_sda;
		r.sda_released = sda_tristate;
		r.busy_res     = seq_busy;
		r.done_res     = fin;
		r.rx_byte      = rx_hold;
		r.ack_seen     = ack_hold;
		return r;
	endfunction

	function automatic cmd_beat_t make_beat(input logic [2:0] op, input logic [7:0] data,
			input logic ack, input logic sample);
		cmd_beat_t b;
		b.op         = op;
		b.write_byte = data;
		b.send_ack   = ack;
		b.sda_sample = sample;
		return b;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int tick_count(input logic [2:0] op);
		if (op == OP_WRITE)
			return WRITE_TICKS;
		if (op == OP_READ)
			return READ_TICKS;
		return START_STOP_TICKS;
	endfunction

	// SDA level the slave side presents on tick number idx of a sequence: the data bits
	// of a read on its sampling ticks, the acknowledge on the last tick of a write.
	function automatic logic line_sample(input logic [2:0] op, input int idx,
			input logic [7:0] line_bits, input logic ack_bit);
		if (op == OP_WRITE && idx == WRITE_TICKS - 1)
			return ack_bit;
		if (op == OP_READ && idx >= int'(RD_FIRST_BIT) && idx <= int'(RD_LAST_BIT) && idx[0])
			return line_bits[3'(7 - (idx - int'(RD_FIRST_BIT)) / 2)];
		return 1'($urandom);
	endfunction

	// A stray beat: a command, refused if a sequence is running, or an undefined op, which is ignored.
	function automatic cmd_beat_t noise_beat();
		logic [2:0] op;
		if ($urandom_range(0, 1))
			op = 3'($urandom_range(OP_START, OP_READ));
		else
			op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
		return make_beat(op, 8'($urandom), 1'($urandom), 1'($urandom));
	endfunction

	function automatic void compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			error_count++;
		end
	endfunction

	// Offers one beat from the falling edge on and holds it until the engine takes it.
	// Valid is only lowered when a gap is inserted, never in the step that raises it.
	task automatic send_beat(input cmd_beat_t b);
		int gap;
		gap = (src_idle && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			cmd_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		cmd_valid <= 1'b1;
		cmd_beat  <= b;
		@(posedge clk);
		while (cmd_stall !== 1'b0) @(posedge clk);
		if (b.op <= OP_READ || (b.op == OP_TICK && seq_busy))
			live_beats++;
		expected_rsp.push_back(engine_predict(b));
		beats_sent++;
	endtask

	// Feeds count ticks to a running sequence, with optional stray beats mixed in.
	task automatic play_ticks(input logic [2:0] op, input int count, input logic [7:0] line_bits,
			input logic ack_bit, input int noise_pct);
		for (int i = 0; i < count; i++) begin
			if (noise_pct > 0 && $urandom_range(1, 100) <= noise_pct)
				send_beat(noise_beat());
			send_beat(make_beat(OP_TICK, 8'($urandom), 1'($urandom),
				line_sample(op, i, line_bits, ack_bit)));
		end
	endtask

	// One command and its ticks. With noise on, a few sequences are cut short so that
	// the next command lands on a busy engine and its ticks finish the old sequence.
	task automatic play_sequence(input cmd_beat_t c, input logic [7:0] line_bits,
			input logic ack_bit, input int noise_pct);
		int n;
		n = tick_count(c.op);
		if (noise_pct > 0 && $urandom_range(0, 9) == 0)
			n = $urandom_range(0, n - 1);
		send_beat(c);
		play_ticks(c.op, n, line_bits, ack_bit, noise_pct);
	endtask

	task automatic pause_until_drained();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
	endtask

	// Ticks while idle and undefined ops must leave the reset state untouched.
	task automatic check_idle_items();
		send_beat(make_beat(OP_TICK, 8'h00, 1'b0, 1'b0));
		send_beat(make_beat(OP_TICK, 8'hFF, 1'b1, 1'b1));
		for (int op = int'(OP_UNUSED_LO); op <= int'(OP_UNUSED_HI); op++) begin
			send_beat(make_beat(3'(op), 8'hFF, 1'b1, 1'b1));
			send_beat(make_beat(3'(op), 8'h00, 1'b0, 1'b0));
		end
	endtask

	// Every command with the data extremes, a refused command and an ignored op mid-sequence.
	task automatic check_line_sequences();
		play_sequence(make_beat(OP_START, 8'h00, 1'b0, 1'b0), 8'h00, 1'b0, 0);
		play_sequence(make_beat(OP_WRITE, 8'hFF, 1'b0, 1'b1), 8'h00, 1'b0, 0);
		send_beat(make_beat(OP_WRITE, 8'h00, 1'b1, 1'b0));
		send_beat(make_beat(OP_UNUSED_HI, 8'hFF, 1'b1, 1'b1));
		send_beat(make_beat(OP_READ, 8'hFF, 1'b1, 1'b1));
		play_ticks(OP_WRITE, WRITE_TICKS, 8'h00, 1'b1, 0);
		play_sequence(make_beat(OP_READ, 8'h00, 1'b1, 1'b0), 8'hFF, 1'b0, 0);
		play_sequence(make_beat(OP_READ, 8'hFF, 1'b0, 1'b1), 8'h00, 1'b0, 0);
		play_sequence(make_beat(OP_STOP, 8'hFF, 1'b1, 1'b1), 8'h00, 1'b0, 0);
	endtask

	// The receiver stalls for a long stretch while beats keep coming, so the engine
	// must fill up and hold off its input; afterwards the sender waits for the backlog.
	task automatic check_backpressure();
		src_idle  = 1'b0;
		sink_idle = 1'b0;
		hold_left = 60;
		play_sequence(make_beat(OP_START, 8'($urandom), 1'($urandom), 1'($urandom)),
			8'($urandom), 1'($urandom), 0);
		play_sequence(make_beat(OP_WRITE, 8'($urandom), 1'($urandom), 1'($urandom)),
			8'($urandom), 1'($urandom), 0);
		pause_until_drained();
	endtask

	// Mostly well-formed sequences with random data, some noise and broken sequences.
	// Idling on each side is switched every few sequences so that quiet stretches occur.
	task automatic check_random_traffic(input int goal);
		int        first;
		int        seq_no;
		cmd_beat_t c;
		first  = beats_sent;
		seq_no = 0;
		while (beats_sent - first < goal) begin
			if (seq_no % 8 == 0) begin
				src_idle  = ($urandom_range(0, 3) != 0);
				sink_idle = ($urandom_range(0, 3) != 0);
			end
			if ($urandom_range(0, 7) == 0)
				send_beat(noise_beat());
			c = make_beat(3'($urandom_range(OP_START, OP_READ)), 8'($urandom),
				1'($urandom), 1'($urandom));
			play_sequence(c, 8'($urandom), 1'($urandom), 6);
			seq_no++;
		end
	endtask

	// Result stall: an explicit hold-off wins, otherwise random runs of stall cycles while the sink idles.
	initial begin : sink_stall
		int run;
		run = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else if (!sink_idle) begin
				rsp_stall <= 1'b0;
			end else if (run > 0) begin
				rsp_stall <= 1'b1;
				run--;
			end else if ($urandom_range(0, 3) == 0) begin
				rsp_stall <= 1'b1;
				run = pick_gap() - 1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// Every accepted result beat is matched against the oldest prediction.
	always @(posedge clk) begin : rsp_check
		rsp_beat_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (expected_rsp.size() == 0) begin
				$error("result beat arrived with no command beat waiting for it");
				error_count++;
			end else begin
				want = expected_rsp.pop_front();
				compare_field("scl_level", 8'(want.scl_level), 8'(rsp_beat.scl_level));
				compare_field("sda_level", 8'(want.sda_level), 8'(rsp_beat.sda_level));
				compare_field("sda_released", 8'(want.sda_released),
					8'(rsp_beat.sda_released));
				compare_field("busy_res", 8'(want.busy_res), 8'(rsp_beat.busy_res));
				compare_field("done_res", 8'(want.done_res), 8'(rsp_beat.done_res));
				compare_field("rx_byte", want.rx_byte, rsp_beat.rx_byte);
				compare_field("ack_seen", 8'(want.ack_seen), 8'(rsp_beat.ack_seen));
				compare_field("rejected", 8'(want.rejected), 8'(rsp_beat.rejected));
				rsp_checked++;
				if (want.done_res)
					seq_finished++;
				if (want.rejected)
					cmd_refused++;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		check_idle_items();
		check_line_sequences();
		check_backpressure();
		src_idle  = 1'b1;
		sink_idle = 1'b1;
		check_random_traffic(RANDOM_BEATS);

		pause_until_drained();
		repeat (10) @(posedge clk);
		if (expected_rsp.size() != 0) begin
			$error("%0d predicted results never arrived", expected_rsp.size());
			error_count++;
		end

		$display("Sent %0d beats (%0d reached the sequencer), checked %0d result beats.",
			beats_sent, live_beats, rsp_checked);
		$display("%0d sequences ran to the end, %0d commands were refused, %0d mismatches.",
			seq_finished, cmd_refused, error_count);
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
